[design/ackf_pkg.sv]
// Shared types, widths, constants and lookup functions of the Ackley evaluator.
// Used by the channel interfaces, the divider, the square root unit and the top level.
package ackf_pkg;

  localparam int COORD_W      = 23;
  localparam int FIT_W        = 26;
  localparam int NDIM_W       = 11;
  localparam int BIAS_W       = 25;
  localparam int SSQ_W        = 48;
  localparam int SCOS_W       = 32;
  localparam int ROOT_W       = 32;
  localparam int RAD_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 25;
  localparam int DEF_MAX_DIMS = 1024;
  localparam int DIV_STEPS    = 48;
  localparam int SQRT_STEPS   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS     = 2'd1;

  localparam logic [NDIM_W-1:0]   NUM_DIMS_RST = 11'd2;
  localparam logic signed [32:0]  CORDIC_X0    = 33'sd652032874;
  localparam logic [31:0]         ANG_SCALE    = 32'd411775;
  localparam logic [31:0]         LOG2E_Q30    = 32'd1549082005;
  localparam logic signed [39:0]  TWENTY_E_Q16 = 40'sd1488865;
  localparam logic signed [39:0]  FIT_MAX      = 40'sd33554431;
  localparam logic signed [39:0]  FIT_MIN      = -40'sd33554432;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [FIT_W-1:0]   fit_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_ANG,
    ST_CINIT,
    ST_CORD,
    ST_CACC,
    ST_DSQ,
    ST_DSQ_W,
    ST_DCOS,
    ST_DCOS_W,
    ST_SQRT,
    ST_SQRT_W,
    ST_DIV5,
    ST_DIV5_W,
    ST_XMUL,
    ST_XW,
    ST_XPROD,
    ST_XPACC,
    ST_XFIN,
    ST_SUM
  } ackf_state_t;

  // atan(2^-i) in Q16 radians.
  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd51472;
      4'd1:    v = 17'd30386;
      4'd2:    v = 17'd16055;
      4'd3:    v = 17'd8150;
      4'd4:    v = 17'd4091;
      4'd5:    v = 17'd2047;
      4'd6:    v = 17'd1024;
      4'd7:    v = 17'd512;
      4'd8:    v = 17'd256;
      4'd9:    v = 17'd128;
      4'd10:   v = 17'd64;
      4'd11:   v = 17'd32;
      4'd12:   v = 17'd16;
      4'd13:   v = 17'd8;
      4'd14:   v = 17'd4;
      default: v = 17'd2;
    endcase
    return v;
  endfunction

  // 2^(2^-(j+1)) in Q30.
  function automatic logic [31:0] root2_q30(input logic [3:0] j);
    logic [31:0] v;
    case (j)
      4'd0:    v = 32'd1518500250;
      4'd1:    v = 32'd1276901417;
      4'd2:    v = 32'd1170923762;
      4'd3:    v = 32'd1121280436;
      4'd4:    v = 32'd1097253708;
      4'd5:    v = 32'd1085434106;
      4'd6:    v = 32'd1079572136;
      4'd7:    v = 32'd1076653033;
      4'd8:    v = 32'd1075196443;
      4'd9:    v = 32'd1074468888;
      4'd10:   v = 32'd1074105294;
      4'd11:   v = 32'd1073923544;
      4'd12:   v = 32'd1073832680;
      4'd13:   v = 32'd1073787251;
      4'd14:   v = 32'd1073764537;
      default: v = 32'd1073753181;
    endcase
    return v;
  endfunction

endpackage

[design/ackf_in_if.sv]
// Input channel carrying one coordinate per beat.
// Depends on ackf_pkg for the payload type.
interface ackf_in_if;
  import ackf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t coordinate;
  modport source (output valid, output coordinate, input ready);
  modport sink (input valid, input coordinate, output ready);
endinterface

[design/ackf_out_if.sv]
// Result channel carrying one fitness value per beat.
// Depends on ackf_pkg for the payload type.
interface ackf_out_if;
  import ackf_pkg::*;
  logic valid;
  logic ready;
  fit_t fitness;
  modport source (output valid, output fitness, input ready);
  modport sink (input valid, input fitness, output ready);
endinterface

[design/ackley_function_eval.sv]
// Ackley function evaluator: sequencer, shared multiplier, CORDIC and exponent datapath.
// Depends on ackf_pkg, ackf_in_if, ackf_out_if, ackf_div and ackf_sqrt.
// Each accepted coordinate beat keeps ready low until its sequence is through: one
// squaring multiply, one angle multiply, a CORDIC setup, 16 rotations on the shared
// adders and one accumulate. The last coordinate of a point keeps ready low further,
// for two 48-step divisions, a 32-step root, a reciprocal multiply for the divide by
// five and two exponents; a result still waiting at the output adds its stall.
// Reset is synchronous and active low; it clears the sums, the coordinate count, the
// output valid flag and sets the dimension to two and the bias to zero.
module ackley_function_eval #(
  parameter int MAX_DIMS = ackf_pkg::DEF_MAX_DIMS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ackf_in_if.sink                         in_ch,
  ackf_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ackf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ackf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ackf_pkg::*;

  // Quadrant codes taken from the top two bits of the phase.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Divide by five as a multiply by ceil(2^29/5) and a shift by 29. The result is
  // exact for dividends below 2^29/3, well above the largest root plus two.
  localparam logic [31:0] DIV5_RECIP = 32'd107374183;
  localparam int          DIV5_SHIFT = 29;

  // Control and accumulated state.
  ackf_state_t              state_r, state_nxt;
  logic [NDIM_W-1:0]        nd_r, nd_nxt;
  logic signed [BIAS_W-1:0] bias_r, bias_nxt;
  logic [SSQ_W-1:0]         sum_sq_r, sum_sq_nxt;
  logic signed [SCOS_W-1:0] sum_cos_r, sum_cos_nxt;
  logic [NDIM_W-1:0]        count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [4:0]               it_r, it_nxt;
  logic                     xsel_r, xsel_nxt;

  // Datapath registers.
  coord_t                   x_r, x_nxt;
  logic [63:0]              p_r;
  logic signed [32:0]       cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [19:0]       z_r, z_nxt;
  logic [SSQ_W-1:0]         mean_sq_r, mean_sq_nxt;
  logic                     cos_neg_r, cos_neg_nxt;
  logic [31:0]              cos_mag_r, cos_mag_nxt;
  logic [ROOT_W-1:0]        root_r, root_nxt;
  logic [31:0]              u_r, u_nxt;
  logic [31:0]              y_r, y_nxt;
  logic [15:0]              f_r, f_nxt;
  logic [5:0]               kk_r, kk_nxt;
  logic [16:0]              t1_r, t1_nxt;
  logic [32:0]              t2_r, t2_nxt;
  fit_t                     fit_r, fit_nxt;

  // Combinational helpers.
  logic [31:0]              mul_a, mul_b;
  logic [COORD_W-1:0]       x_abs;
  logic [NDIM_W-1:0]        nd_one;
  logic [NDIM_W-1:0]        n_eff;
  logic signed [32:0]       dx, dy;
  logic signed [19:0]       atan_v;
  logic signed [32:0]       c_raw, s_raw;
  logic signed [17:0]       c_sat, s_sat, cos_v;
  logic [SCOS_W-1:0]        cos_abs;
  logic                     div_start, div_done;
  logic [SSQ_W-1:0]         div_dvd, div_q;
  logic [NDIM_W-1:0]        div_dvs;
  logic                     sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]        sqrt_root;
  logic                     xneg;
  logic [33:0]              wm;
  logic [21:0]              wp;
  logic [5:0]               sh;
  logic [47:0]              tsh;
  logic [32:0]              t_val;
  logic [39:0]              t1x20;
  logic signed [39:0]       fit_full;

  function automatic logic signed [17:0] clamp_unit(input logic signed [32:0] v);
    logic signed [17:0] r;
    if (v > 33'sd65536) begin
      r = 18'sd65536;
    end else if (v < -33'sd65536) begin
      r = -18'sd65536;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  // Effective dimension: zero acts as one, and the count is capped at MAX_DIMS.
  assign nd_one = (nd_r == '0) ? NDIM_W'(1) : nd_r;
  assign n_eff  = ({21'b0, nd_one} > 32'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : nd_one;

  assign x_abs   = x_r[COORD_W-1] ? COORD_W'(-x_r) : COORD_W'(x_r);
  assign cos_abs = sum_cos_r[SCOS_W-1] ? SCOS_W'(-sum_cos_r) : SCOS_W'(sum_cos_r);

  // One shared multiplier; the product is registered before any use.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        mul_a = 32'(x_abs);
        mul_b = 32'(x_abs);
      end
      ST_ANG: begin
        mul_a = {18'b0, x_r[13:0]};
        mul_b = ANG_SCALE;
      end
      ST_DIV5: begin
        mul_a = root_r + 32'd2;
        mul_b = DIV5_RECIP;
      end
      ST_XMUL: begin
        mul_a = xsel_r ? cos_mag_r : u_r;
        mul_b = LOG2E_Q30;
      end
      ST_XPROD: begin
        mul_a = y_r;
        mul_b = root2_q30(it_r[3:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The divider serves both means.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = sum_sq_r;
    div_dvs   = n_eff;
    case (state_r)
      ST_DSQ: begin
        div_start = 1'b1;
      end
      ST_DCOS: begin
        div_start = 1'b1;
        div_dvd   = SSQ_W'(cos_abs);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (state_r == ST_SQRT);

  ackf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  ackf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({mean_sq_r, 16'b0}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // CORDIC rotation terms and the cosine pick-off.
  assign dx     = cy_r >>> it_r[3:0];
  assign dy     = cx_r >>> it_r[3:0];
  assign atan_v = 20'(atan_q16(it_r[3:0]));
  assign c_raw  = (cx_r + 33'sd8192) >>> 14;
  assign s_raw  = (cy_r + 33'sd8192) >>> 14;
  assign c_sat  = clamp_unit(c_raw);
  assign s_sat  = clamp_unit(s_raw);

  always_comb begin
    case (x_r[15:14])
      QUAD_0:  cos_v = c_sat;
      QUAD_1:  cos_v = -s_sat;
      QUAD_2:  cos_v = -c_sat;
      default: cos_v = s_sat;
    endcase
  end

  // Exponent helpers: the base-2 exponent, and the final rounding shift by its
  // integer part.
  assign xneg = xsel_r ? cos_neg_r : 1'b1;
  always_comb begin
    wm = 34'((p_r + 64'h2000_0000) >> 30);
    if (!xneg && (wm >= 34'd1048576)) begin
      wm = 34'd1048575;
    end
  end
  assign wp = xneg ? 22'(34'd2097152 - wm) : 22'(34'd2097152 + wm);

  always_comb begin
    sh  = 6'd46 - kk_r;
    tsh = ({16'b0, y_r} + (48'd1 << (sh - 6'd1))) >> sh;
    if (kk_r >= 6'd46) begin
      t_val = {1'b0, y_r} << (kk_r - 6'd46);
    end else begin
      t_val = tsh[32:0];
    end
  end

  // Final sum: 20 + e + bias - 20*t1 - t2, then saturate.
  assign t1x20    = ({23'b0, t1_r} << 4) + ({23'b0, t1_r} << 2);
  assign fit_full = TWENTY_E_Q16 + 40'(bias_r) - $signed(t1x20) - $signed({7'b0, t2_r});

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    nd_nxt        = nd_r;
    bias_nxt      = bias_r;
    sum_sq_nxt    = sum_sq_r;
    sum_cos_nxt   = sum_cos_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    it_nxt        = it_r;
    xsel_nxt      = xsel_r;
    x_nxt         = x_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    z_nxt         = z_r;
    mean_sq_nxt   = mean_sq_r;
    cos_neg_nxt   = cos_neg_r;
    cos_mag_nxt   = cos_mag_r;
    root_nxt      = root_r;
    u_nxt         = u_r;
    y_nxt         = y_r;
    f_nxt         = f_r;
    kk_nxt        = kk_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    fit_nxt       = fit_r;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_DIMS: nd_nxt   = cfg_data[NDIM_W-1:0];
        CFG_BIAS:     bias_nxt = $signed(cfg_data[BIAS_W-1:0]);
        default:      nd_nxt   = nd_r;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt     = in_ch.coordinate;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        // The product register now holds x*x.
        sum_sq_nxt = sum_sq_r + SSQ_W'((p_r + 64'd32768) >> 16);
        state_nxt  = ST_CINIT;
      end
      ST_CINIT: begin
        // The product register now holds the scaled phase.
        z_nxt     = 20'((p_r + 64'd32768) >> 16);
        cx_nxt    = CORDIC_X0;
        cy_nxt    = '0;
        it_nxt    = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        if (!z_r[19]) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - atan_v;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + atan_v;
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd15) begin
          state_nxt = ST_CACC;
        end
      end
      ST_CACC: begin
        sum_cos_nxt = sum_cos_r + SCOS_W'(cos_v);
        count_nxt   = count_r + NDIM_W'(1);
        if ((count_r + NDIM_W'(1)) >= n_eff) begin
          state_nxt = ST_DSQ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DSQ: begin
        state_nxt = ST_DSQ_W;
      end
      ST_DSQ_W: begin
        if (div_done) begin
          mean_sq_nxt = div_q;
          state_nxt   = ST_DCOS;
        end
      end
      ST_DCOS: begin
        state_nxt = ST_DCOS_W;
      end
      ST_DCOS_W: begin
        if (div_done) begin
          cos_mag_nxt = div_q[31:0];
          cos_neg_nxt = sum_cos_r[SCOS_W-1];
          state_nxt   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        state_nxt = ST_SQRT_W;
      end
      ST_SQRT_W: begin
        if (sqrt_done) begin
          root_nxt  = sqrt_root;
          state_nxt = ST_DIV5;
        end
      end
      ST_DIV5: begin
        state_nxt = ST_DIV5_W;
      end
      ST_DIV5_W: begin
        // The product register now holds (root + 2) times the reciprocal of five.
        u_nxt     = 32'(p_r >> DIV5_SHIFT);
        xsel_nxt  = 1'b0;
        state_nxt = ST_XMUL;
      end
      ST_XMUL: begin
        state_nxt = ST_XW;
      end
      ST_XW: begin
        y_nxt  = 32'h4000_0000;
        it_nxt = '0;
        if (xneg && (wm > 34'd2097152)) begin
          // Deep underflow: a zero fraction and the largest right shift give zero.
          f_nxt  = '0;
          kk_nxt = '0;
        end else begin
          f_nxt  = wp[15:0];
          kk_nxt = wp[21:16];
        end
        state_nxt = ST_XPROD;
      end
      ST_XPROD: begin
        if (it_r == 5'd16) begin
          state_nxt = ST_XFIN;
        end else if (f_r[4'd15 - it_r[3:0]]) begin
          state_nxt = ST_XPACC;
        end else begin
          it_nxt = it_r + 5'd1;
        end
      end
      ST_XPACC: begin
        y_nxt     = 32'((p_r + 64'h2000_0000) >> 30);
        it_nxt    = it_r + 5'd1;
        state_nxt = ST_XPROD;
      end
      ST_XFIN: begin
        if (!xsel_r) begin
          t1_nxt    = t_val[16:0];
          xsel_nxt  = 1'b1;
          state_nxt = ST_XMUL;
        end else begin
          t2_nxt    = t_val;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // Hold here until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          if (fit_full > FIT_MAX) begin
            fit_nxt = FIT_MAX[FIT_W-1:0];
          end else if (fit_full < FIT_MIN) begin
            fit_nxt = FIT_MIN[FIT_W-1:0];
          end else begin
            fit_nxt = fit_full[FIT_W-1:0];
          end
          out_valid_nxt = 1'b1;
          sum_sq_nxt    = '0;
          sum_cos_nxt   = '0;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nd_r        <= NUM_DIMS_RST;
      bias_r      <= '0;
      sum_sq_r    <= '0;
      sum_cos_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
      xsel_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nd_r        <= nd_nxt;
      bias_r      <= bias_nxt;
      sum_sq_r    <= sum_sq_nxt;
      sum_cos_r   <= sum_cos_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      it_r        <= it_nxt;
      xsel_r      <= xsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= 64'(mul_a) * 64'(mul_b);
    x_r       <= x_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    z_r       <= z_nxt;
    mean_sq_r <= mean_sq_nxt;
    cos_neg_r <= cos_neg_nxt;
    cos_mag_r <= cos_mag_nxt;
    root_r    <= root_nxt;
    u_r       <= u_nxt;
    y_r       <= y_nxt;
    f_r       <= f_nxt;
    kk_r      <= kk_nxt;
    t1_r      <= t1_nxt;
    t2_r      <= t2_nxt;
    fit_r     <= fit_nxt;
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.fitness = fit_r;

`ifndef SYNTHESIS
  // An accepted coordinate always starts with the squaring multiply.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == ST_SQ)
    else $error("accepted beat did not start the coordinate sequence");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DSQ_W || state_r == ST_DCOS_W))
    else $error("divider finished outside a wait state");

  // The root unit only finishes while the sequencer waits for it.
  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT_W)
    else $error("square root finished outside its wait state");

  // Leaving the final sum presents a result and clears the running point.
  a_sum_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM && state_nxt == ST_IDLE
      |=> out_valid_r && sum_sq_r == '0 && count_r == '0)
    else $error("result step did not emit and clear");
`endif
endmodule

[design/ackf_div.sv]
// Restoring divider, one quotient bit per cycle, for the two mean steps.
// Depends on ackf_pkg for widths.
module ackf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ackf_pkg::SSQ_W-1:0]  dividend,
  input  logic [ackf_pkg::NDIM_W-1:0] divisor,
  output logic                        done,
  output logic [ackf_pkg::SSQ_W-1:0]  quotient
);
  import ackf_pkg::*;

  logic [SSQ_W-1:0]  quo_r, quo_nxt;
  logic [NDIM_W:0]   rem_r, rem_nxt;
  logic [NDIM_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [NDIM_W+1:0] part;
  logic [NDIM_W+1:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    part     = {rem_r, quo_r[SSQ_W-1]};
    trial    = part - {2'b00, dvs_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = 6'(DIV_STEPS);
    end else if (cnt_r != 6'd0) begin
      if (part >= {2'b00, dvs_r}) begin
        rem_nxt = trial[NDIM_W:0];
        quo_nxt = {quo_r[SSQ_W-2:0], 1'b1};
      end else begin
        rem_nxt = part[NDIM_W:0];
        quo_nxt = {quo_r[SSQ_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

[design/ackf_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on ackf_pkg for widths.
module ackf_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ackf_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [ackf_pkg::ROOT_W-1:0] root
);
  import ackf_pkg::*;

  logic [RAD_W-1:0] v_r, v_nxt;
  logic [RAD_W-1:0] res_r, res_nxt;
  logic [RAD_W-1:0] bit_r, bit_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [RAD_W-1:0] trial;

  always_comb begin
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = res_r + bit_r;
    if (start) begin
      v_nxt   = radicand;
      res_nxt = '0;
      bit_nxt = {2'b01, {(RAD_W-2){1'b0}}};
      cnt_nxt = 6'(SQRT_STEPS);
    end else if (cnt_r != 6'd0) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt  = bit_r >> 2;
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];
endmodule
